[rtl/hssq_pkg.sv]
// Shared types and constants for the half swap sample queue.
// Depends on nothing; the other files in rtl, apart from hssq_ram, take its names by scope.
package hssq_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int PTR_BITS  = $clog2(DEPTH);

  localparam logic [PTR_BITS-1:0] HALF_STEP = PTR_BITS'(DEPTH / 2);
  localparam logic [PTR_BITS-1:0] PTR_ONE   = PTR_BITS'(1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_REFUSE,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic                 cmd;
    logic [WORD_BITS-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [WORD_BITS-1:0] read_data;
    logic [PTR_BITS-1:0]  write_pointer;
    logic [PTR_BITS-1:0]  read_pointer;
    logic [PTR_BITS-1:0]  write_limit;
    logic [PTR_BITS-1:0]  read_limit;
    logic                 can_write;
    logic                 can_read;
  } out_item_t;

  typedef struct packed {
    logic [PTR_BITS-1:0] wr_ptr;
    logic [PTR_BITS-1:0] rd_ptr;
    logic [PTR_BITS-1:0] wr_stop;
    logic [PTR_BITS-1:0] rd_stop;
    logic                fill_mode;
    logic                drain_mode;
  } ctrl_state_t;

  typedef struct packed {
    op_t                  op;
    logic [PTR_BITS-1:0]  addr;
    logic [WORD_BITS-1:0] data;
    out_item_t            res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/half_swap_sample_queue.sv]
// Half swap sample queue: fill/drain circular buffer of 1024 32-bit words.
// Path: each command passes the command queue, the RAM read register and the result register.
// Flow: the back end holds a single command in flight and takes the next only once
// its result is popped; the front takes an item each cycle until the command queue
// holds QUEUE_DEPTH entries.
// Reset: synchronous; clears pointers, stops, queue and result valid, sets fill mode; RAM and result data kept.
module half_swap_sample_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hssq_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output hssq_pkg::out_item_t result
);

  logic                    take;
  logic                    q_pop;
  hssq_pkg::cmd_t          entry;
  hssq_pkg::cmd_t          q_head;
  hssq_pkg::queue_status_t q_status;

  assign full = q_status.full;
  assign take = push && !q_status.full;

  hssq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .entry (entry)
  );

  hssq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (entry),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  hssq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_status.empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_modes_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.can_write != result.can_read))
    else $error("fill and drain modes both set or both clear");

  a_refused_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.accepted) |-> (result.read_data == '0))
    else $error("refused request carries read data");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("command queue both full and empty");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("command queue popped while empty");

endmodule

[rtl/hssq_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module hssq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/hssq_front.sv]
// Front end: holds pointers, stops and modes, classifies each item.
// Depends on hssq_pkg; feeds one command per taken item, refused ones included, to the queue.
module hssq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  hssq_pkg::in_item_t item,
  output hssq_pkg::cmd_t    entry
);

  hssq_pkg::ctrl_state_t st;
  hssq_pkg::ctrl_state_t st_next;
  hssq_pkg::op_t         op;
  logic [hssq_pkg::PTR_BITS-1:0] wp1;
  logic [hssq_pkg::PTR_BITS-1:0] rp1;

  assign wp1 = st.wr_ptr + hssq_pkg::PTR_ONE;
  assign rp1 = st.rd_ptr + hssq_pkg::PTR_ONE;

  always_comb begin
    st_next = st;
    op      = hssq_pkg::OP_REFUSE;
    case (item.cmd)
      hssq_pkg::CMD_WRITE: begin
        if (st.fill_mode) begin
          op             = hssq_pkg::OP_WRITE;
          st_next.wr_ptr = wp1;
          if (wp1 == st.wr_stop) begin
            st_next.wr_stop    = wp1 + hssq_pkg::HALF_STEP;
            st_next.fill_mode  = 1'b0;
            st_next.drain_mode = 1'b1;
          end
        end
      end
      hssq_pkg::CMD_READ: begin
        if (st.drain_mode) begin
          op             = hssq_pkg::OP_READ;
          st_next.rd_ptr = rp1;
          if (rp1 == st.rd_stop) begin
            st_next.rd_stop    = st.rd_stop + hssq_pkg::HALF_STEP;
            st_next.rd_ptr     = st.rd_stop + hssq_pkg::HALF_STEP;
            st_next.fill_mode  = 1'b1;
            st_next.drain_mode = 1'b0;
          end
          if (st_next.rd_ptr == st.wr_ptr) begin
            st_next.fill_mode  = 1'b1;
            st_next.drain_mode = 1'b0;
          end
        end
      end
      default: begin
        op = hssq_pkg::OP_REFUSE;
      end
    endcase
  end

  always_comb begin
    entry                   = '0;
    entry.op                = op;
    entry.addr              = (op == hssq_pkg::OP_WRITE) ? st.wr_ptr : st.rd_ptr;
    entry.data              = item.write_data;
    entry.res.accepted      = (op != hssq_pkg::OP_REFUSE);
    entry.res.read_data     = '0;
    entry.res.write_pointer = st_next.wr_ptr;
    entry.res.read_pointer  = st_next.rd_ptr;
    entry.res.write_limit   = st_next.wr_stop;
    entry.res.read_limit    = st_next.rd_stop;
    entry.res.can_write     = st_next.fill_mode;
    entry.res.can_read      = st_next.drain_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.wr_ptr     <= '0;
      st.rd_ptr     <= '0;
      st.wr_stop    <= '0;
      st.rd_stop    <= '0;
      st.fill_mode  <= 1'b1;
      st.drain_mode <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

[rtl/hssq_fifo.sv]
// Short command queue between the front and back ends.
// Depends on hssq_pkg for the command type.
module hssq_fifo #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  hssq_pkg::cmd_t         push_data,
  input  logic                   pop,
  output hssq_pkg::cmd_t         head,
  output hssq_pkg::queue_status_t status
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  hssq_pkg::cmd_t   slots [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_idx];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + IDX_W'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + IDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/hssq_back.sv]
// Back end: issues each queued command to the sample RAM and holds the result.
// Depends on hssq_pkg and hssq_ram.
module hssq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  hssq_pkg::cmd_t      q_head,
  output logic                q_pop,
  output hssq_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);

  logic                          issue;
  logic                          ram_we;
  logic [hssq_pkg::WORD_BITS-1:0] ram_rdata;
  logic                          s1_valid;
  hssq_pkg::cmd_t                s1;
  hssq_pkg::out_item_t           s1_res;
  logic                          out_valid;
  hssq_pkg::out_item_t           out_res;

  assign issue  = !q_empty && !s1_valid && !out_valid;
  assign q_pop  = issue;
  assign ram_we = issue && (q_head.op == hssq_pkg::OP_WRITE);

  hssq_ram #(
    .WIDTH (hssq_pkg::WORD_BITS),
    .DEPTH (hssq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (q_head.addr),
    .wdata (q_head.data),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_res           = s1.res;
    s1_res.read_data = (s1.op == hssq_pkg::OP_READ) ? ram_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= q_head;
    end
    if (s1_valid) begin
      out_res <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (s1_valid) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result = out_res;
  assign empty  = !out_valid;

endmodule
